/* rtl/wbss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbss_pkg
// shared constants, types and helpers of the wildcard byte signature scanner
// ----------------------------------------------------------------------------
package wbss_pkg;

  localparam int unsigned MAX_PATTERN_BYTES = 16;
  localparam int unsigned POSITION_BITS     = 32;

  localparam int unsigned SigBytes  = 16;
  localparam int unsigned SigIdxW   = 4;
  localparam int unsigned LenW      = 5;
  localparam int unsigned AddrW     = 64;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned WinIdxW   = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  typedef logic [7:0] byte_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_CARE_MASK      = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_REGION_BASE    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [63:0]       pattern_low;
    logic [63:0]       pattern_high;
    logic [SigBytes-1:0] care_mask;
    logic [LenW-1:0]   pattern_length;
    logic [AddrW-1:0]  region_base;
  } cfg_t;

  function automatic byte_t sig_byte(cfg_t cfg, logic [SigIdxW-1:0] idx);
    logic [63:0] word;
    word = idx[SigIdxW-1] ? cfg.pattern_high : cfg.pattern_low;
    return word[{idx[2:0], 3'b000} +: 8];
  endfunction

endpackage

/* rtl/wbss_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbss interfaces
// byte input, result output and configuration write channels
// ----------------------------------------------------------------------------
interface wbss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbss_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [wbss_pkg::AddrW-1:0] match_address;
  modport source (output valid, output found, output match_address, input ready);
  modport sink (input valid, input found, input match_address, output ready);
endinterface

interface wbss_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wbss_pkg::CfgIdxW-1:0]  index;
  logic [wbss_pkg::CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/wbss_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbss_cfg_regs
// configuration register file, one write per cycle, unknown index ignored
// ----------------------------------------------------------------------------
module wbss_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  wbss_cfg_if.sink          cfg_i,
  output wbss_pkg::cfg_t    cfg_o
);
  import wbss_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  cfg_reg_e reg_sel;

  assign cfg_i.ready = 1'b1;
  assign reg_sel     = cfg_reg_e'(cfg_i.index);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (reg_sel)
        REG_PATTERN_LOW:    cfg_d.pattern_low    = cfg_i.data;
        REG_PATTERN_HIGH:   cfg_d.pattern_high   = cfg_i.data;
        REG_CARE_MASK:      cfg_d.care_mask      = cfg_i.data[SigBytes-1:0];
        REG_PATTERN_LENGTH: cfg_d.pattern_length = cfg_i.data[LenW-1:0];
        REG_REGION_BASE:    cfg_d.region_base    = cfg_i.data[AddrW-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/wbss_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbss_match
// parallel masked compare of the byte window against the signature
// ----------------------------------------------------------------------------
module wbss_match (
  input  wbss_pkg::cfg_t  cfg_i,
  input  wbss_pkg::byte_t window_i [wbss_pkg::MAX_PATTERN_BYTES],
  output logic            match_o
);
  import wbss_pkg::*;

  always_comb begin
    logic [LenW-1:0] back_idx;
    logic            care;
    match_o = 1'b1;
    for (int i = 0; i < int'(MAX_PATTERN_BYTES); i++) begin
      // pattern byte i lines up with the byte len-1-i places back
      back_idx = cfg_i.pattern_length - LenW'(i + 1);
      care = cfg_i.care_mask[i] && (LenW'(i) < cfg_i.pattern_length);
      if (care && (window_i[back_idx[WinIdxW-1:0]] != sig_byte(cfg_i, SigIdxW'(i)))) begin
        match_o = 1'b0;
      end
    end
  end

endmodule

/* rtl/wildcard_byte_signature_scan_core.sv */
`timescale 1ns / 1ps
// an accepted byte passes the input register, then the result register (2-stage path)
// throughput: one byte per cycle without stall; a stall holds one byte in the input register
// the window compare and the base + offset add sit between input and result registers
// reset clears window, position, report flag, configuration and both valid flags
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scan_core
// scans a byte stream for the first wildcard signature match in each region
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scan_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  wbss_in_if.sink   in_i,
  wbss_out_if.source out_o,
  wbss_cfg_if.sink  cfg_i
);
  import wbss_pkg::*;

  cfg_t cfg;

  // input register
  logic  in_valid_q, in_valid_d;
  byte_t in_byte_q;
  logic  in_last_q;

  // scan state
  byte_t                    window_q [MAX_PATTERN_BYTES];
  byte_t                    window_d [MAX_PATTERN_BYTES];
  byte_t                    window_sh [MAX_PATTERN_BYTES];
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     reported_q, reported_d;

  // result register
  logic             res_valid_q, res_valid_d;
  logic             res_found_q, res_found_d;
  logic [AddrW-1:0] res_addr_q, res_addr_d;

  logic                     advance;
  logic                     fire;
  logic                     active;
  logic [POSITION_BITS-1:0] seen;
  logic [POSITION_BITS-1:0] len_ext;
  logic [POSITION_BITS-1:0] offset;
  logic                     len_ok;
  logic                     win_match;
  logic                     hit;
  logic                     miss_end;

  wbss_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  always_comb begin
    window_sh[0] = in_byte_q;
    for (int k = 1; k < int'(MAX_PATTERN_BYTES); k++) begin
      window_sh[k] = window_q[k-1];
    end
  end

  wbss_match u_match (
    .cfg_i    (cfg),
    .window_i (window_sh),
    .match_o  (win_match)
  );

  assign advance     = !res_valid_q || out_o.ready;
  assign fire        = in_valid_q && advance;
  assign in_i.ready  = !in_valid_q || advance;

  assign active   = !reported_q && (pos_q != '1);
  assign seen     = pos_q + POSITION_BITS'(1);
  assign len_ext  = POSITION_BITS'(cfg.pattern_length);
  assign len_ok   = (cfg.pattern_length != '0)
                 && (cfg.pattern_length <= LenW'(MAX_PATTERN_BYTES))
                 && (seen >= len_ext);
  assign offset   = seen - len_ext;
  assign hit      = active && len_ok && win_match;
  assign miss_end = in_last_q && !reported_q && !hit;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_i.valid && in_i.ready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    window_d    = window_q;
    pos_d       = pos_q;
    reported_d  = reported_q;
    res_valid_d = res_valid_q && !out_o.ready;
    res_found_d = res_found_q;
    res_addr_d  = res_addr_q;
    if (fire) begin
      res_valid_d = hit || miss_end;
      res_found_d = hit;
      res_addr_d  = hit ? (cfg.region_base + AddrW'(offset)) : '0;
      if (in_last_q) begin
        for (int k = 0; k < int'(MAX_PATTERN_BYTES); k++) begin
          window_d[k] = '0;
        end
        pos_d      = '0;
        reported_d = 1'b0;
      end else begin
        window_d   = window_sh;
        pos_d      = active ? seen : pos_q;
        reported_d = reported_q || hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      pos_q       <= '0;
      reported_q  <= 1'b0;
      for (int k = 0; k < int'(MAX_PATTERN_BYTES); k++) begin
        window_q[k] <= '0;
      end
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
      pos_q       <= pos_d;
      reported_q  <= reported_d;
      window_q    <= window_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
    res_found_q <= res_found_d;
    res_addr_q  <= res_addr_d;
  end

  assign out_o.valid         = res_valid_q;
  assign out_o.found         = res_found_q;
  assign out_o.match_address = res_addr_q;

  // not found always carries a zero address
  a_miss_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_found_q |-> res_addr_q == '0)
    else $error("not found result with nonzero address");

  // region end rearms the scan
  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_last_q |=> !reported_q && pos_q == '0)
    else $error("scan state not cleared at region end");

  // nothing more is reported once a region has matched
  a_single_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && reported_q && !in_last_q |=> !res_valid_q)
    else $error("second result in one region");

  // position frozen after the match
  a_pos_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && reported_q && !in_last_q |=> pos_q == $past(pos_q))
    else $error("position moved after report");

  // a buffered byte waits while the result side is stalled
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("buffered byte dropped under stall");

endmodule
